// ===== rtl/core/hjg_pkg.sv =====
// shared widths, constants and types of the halton jitter generator
package hjg_pkg;

    // field widths
    localparam int FRAME_W   = 31;
    localparam int COUNT_W   = 11;
    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = 16;

    // phase count limit and the largest base-3 denominator (3^7) in bits
    localparam int MAX_PHASES = 1024;
    localparam int DEN_W      = 12;

    // iteration counter width and counts of the two long divisions
    localparam int ITER_W      = 5;
    localparam int MOD_STEPS   = FRAME_W;
    localparam int FRAC_STEPS  = FRAC_BITS;

    // reciprocal of three for an 11-bit value: q = (n * 683) >> 11
    localparam int RECIP3_W     = 10;
    localparam int RECIP3_SHIFT = 11;
    localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(683);

    // reset value of the phase count register
    localparam logic [COUNT_W-1:0] PHASE_COUNT_RESET = COUNT_W'(8);

    // result of one restoring division step
    typedef struct packed {
        logic             q_bit;
        logic [DEN_W-1:0] rem;
    } step_t;

endpackage

// ===== rtl/core/hjg_if.sv =====
// valid/ready channels of the halton jitter generator

// frame index item channel
interface hjg_frame_if;
    logic                         valid;
    logic                         ready;
    logic [hjg_pkg::FRAME_W-1:0]  frame_index;

    modport source (output valid, output frame_index, input ready);
    modport sink   (input valid, input frame_index, output ready);
endinterface

// jitter pair item channel
interface hjg_jitter_if;
    logic                              valid;
    logic                              ready;
    logic signed [hjg_pkg::OUT_W-1:0]  jitter_x;
    logic signed [hjg_pkg::OUT_W-1:0]  jitter_y;

    modport source (output valid, output jitter_x, output jitter_y, input ready);
    modport sink   (input valid, input jitter_x, input jitter_y, output ready);
endinterface

// ===== rtl/core/hjg_div_step.sv =====
// shared restoring division step: shift in one bit, compare and subtract
module hjg_div_step
(
    input  logic [hjg_pkg::DEN_W-1:0] rem,
    input  logic                      bit_in,
    input  logic [hjg_pkg::DEN_W-1:0] divisor,
    output hjg_pkg::step_t            result
);

    logic [hjg_pkg::DEN_W:0] shifted;
    logic [hjg_pkg::DEN_W:0] diff;
    logic                    fits;

    // partial remainder with the next dividend bit
    assign shifted = {rem, bit_in};
    assign fits    = (shifted >= {1'b0, divisor});
    assign diff    = shifted - {1'b0, divisor};

    // remainder stays below the divisor, so it fits back in DEN_W bits
    always_comb
    begin
        result.q_bit = fits;
        result.rem   = fits ? diff[hjg_pkg::DEN_W-1:0] : shifted[hjg_pkg::DEN_W-1:0];
    end

endmodule

// ===== rtl/core/halton_jitter_generator.sv =====
// halton jitter generator top level: sequencer around one shared division step
// one item at a time: the shared compare-subtract step is
//   used 31 times for the phase modulo and 16 times for the base-3 fraction
// the next item is taken while a finished result still waits to be delivered
// reset: asynchronous, active low; phase count returns to 8, no item in flight
module halton_jitter_generator
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hjg_pkg::COUNT_W-1:0]      cfg_wdata,
    hjg_frame_if.sink                        frame_in,
    hjg_jitter_if.source                     jitter_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DIGIT,
        ST_FRAC,
        ST_DONE
    } state_t;

    state_t                            state_reg, state_next;
    logic [hjg_pkg::COUNT_W-1:0]       phase_count_reg, phase_count_next;
    logic [hjg_pkg::ITER_W-1:0]        iter_reg, iter_next;
    logic [hjg_pkg::FRAME_W-1:0]       frame_reg, frame_next;
    logic [hjg_pkg::DEN_W-1:0]         rem_reg, rem_next;
    logic [hjg_pkg::COUNT_W-1:0]       n_reg, n_next;
    logic [hjg_pkg::DEN_W-1:0]         num_reg, num_next;
    logic [hjg_pkg::DEN_W-1:0]         den_reg, den_next;
    logic [hjg_pkg::FRAC_BITS-1:0]     xq_reg, xq_next;
    logic [hjg_pkg::FRAC_BITS-1:0]     yq_reg, yq_next;
    logic                              out_valid_reg, out_valid_next;
    logic [hjg_pkg::OUT_W-1:0]         jx_reg, jx_next;
    logic [hjg_pkg::OUT_W-1:0]         jy_reg, jy_next;

    logic [hjg_pkg::COUNT_W-1:0]       count_eff;
    logic [hjg_pkg::DEN_W-1:0]         divisor;
    logic                              bit_in;
    hjg_pkg::step_t                    step;
    logic [hjg_pkg::COUNT_W-1:0]       phase;
    logic [hjg_pkg::FRAC_BITS-1:0]     phase_rev;
    logic [hjg_pkg::COUNT_W+hjg_pkg::RECIP3_W-1:0] prod3;
    logic [hjg_pkg::RECIP3_W-1:0]      q3;
    logic [hjg_pkg::DEN_W-1:0]         three_q;
    logic [hjg_pkg::DEN_W-1:0]         digit_full;
    logic [1:0]                        digit;
    logic [hjg_pkg::DEN_W:0]           num3;
    logic [hjg_pkg::DEN_W:0]           den3;
    logic                              out_free;

    // phase count clamped to 1..MAX_PHASES
    always_comb
    begin
        if (phase_count_reg == '0)
        begin
            count_eff = hjg_pkg::COUNT_W'(1);
        end
        else if (phase_count_reg > hjg_pkg::COUNT_W'(hjg_pkg::MAX_PHASES))
        begin
            count_eff = hjg_pkg::COUNT_W'(hjg_pkg::MAX_PHASES);
        end
        else
        begin
            count_eff = phase_count_reg;
        end
    end

    // operands of the shared step: modulo by phase count, then fraction by 3^k
    assign divisor = (state_reg == ST_MOD) ? {{(hjg_pkg::DEN_W-hjg_pkg::COUNT_W){1'b0}}, count_eff}
                                           : den_reg;
    assign bit_in  = (state_reg == ST_MOD) ? frame_reg[hjg_pkg::FRAME_W-1] : 1'b0;

    hjg_div_step u_step
    (
        .rem     (rem_reg),
        .bit_in  (bit_in),
        .divisor (divisor),
        .result  (step)
    );

    // phase from the final remainder; base 2 radical inverse is a bit reversal
    assign phase = step.rem[hjg_pkg::COUNT_W-1:0] + hjg_pkg::COUNT_W'(1);

    always_comb
    begin
        phase_rev = '0;
        for (int i = 0; i < hjg_pkg::COUNT_W; i++)
        begin
            phase_rev[hjg_pkg::FRAC_BITS-1-i] = phase[i];
        end
    end

    // one base-3 digit: divide by three through the reciprocal
    assign prod3      = n_reg * hjg_pkg::RECIP3;
    assign q3         = prod3[hjg_pkg::RECIP3_SHIFT +: hjg_pkg::RECIP3_W];
    assign three_q    = {1'b0, q3, 1'b0} + {2'b00, q3};
    assign digit_full = {1'b0, n_reg} - three_q;
    assign digit      = digit_full[1:0];
    assign num3       = {num_reg, 1'b0} + {1'b0, num_reg} + {{(hjg_pkg::DEN_W-1){1'b0}}, digit};
    assign den3       = {den_reg, 1'b0} + {1'b0, den_reg};

    assign out_free = !out_valid_reg || jitter_out.ready;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        phase_count_next = phase_count_reg;
        iter_next        = iter_reg;
        frame_next       = frame_reg;
        rem_next         = rem_reg;
        n_next           = n_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        xq_next          = xq_reg;
        yq_next          = yq_reg;
        out_valid_next   = out_valid_reg;
        jx_next          = jx_reg;
        jy_next          = jy_reg;

        if (cfg_we)
        begin
            phase_count_next = cfg_wdata;
        end

        if (out_valid_reg && jitter_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_in.valid)
                begin
                    frame_next = frame_in.frame_index;
                    rem_next   = '0;
                    iter_next  = hjg_pkg::ITER_W'(hjg_pkg::MOD_STEPS - 1);
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                frame_next = {frame_reg[hjg_pkg::FRAME_W-2:0], 1'b0};
                rem_next   = step.rem;
                iter_next  = iter_reg - hjg_pkg::ITER_W'(1);
                if (iter_reg == '0)
                begin
                    n_next     = phase;
                    xq_next    = phase_rev;
                    num_next   = '0;
                    den_next   = hjg_pkg::DEN_W'(1);
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (n_reg == '0)
                begin
                    rem_next   = num_reg;
                    iter_next  = hjg_pkg::ITER_W'(hjg_pkg::FRAC_STEPS - 1);
                    state_next = ST_FRAC;
                end
                else
                begin
                    n_next   = q3;
                    num_next = num3[hjg_pkg::DEN_W-1:0];
                    den_next = den3[hjg_pkg::DEN_W-1:0];
                end
            end
            ST_FRAC:
            begin
                rem_next  = step.rem;
                yq_next   = {yq_reg[hjg_pkg::FRAC_BITS-2:0], step.q_bit};
                iter_next = iter_reg - hjg_pkg::ITER_W'(1);
                if (iter_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // subtracting one half flips the top bit of a 16-bit fraction
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    jx_next        = {~xq_reg[hjg_pkg::FRAC_BITS-1], xq_reg[hjg_pkg::FRAC_BITS-2:0]};
                    jy_next        = {~yq_reg[hjg_pkg::FRAC_BITS-1], yq_reg[hjg_pkg::FRAC_BITS-2:0]};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, phase count, iteration count and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_count_reg <= hjg_pkg::PHASE_COUNT_RESET;
            out_valid_reg   <= 1'b0;
            iter_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_count_reg <= phase_count_next;
            out_valid_reg   <= out_valid_next;
            iter_reg        <= iter_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        rem_reg   <= rem_next;
        n_reg     <= n_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        xq_reg    <= xq_next;
        yq_reg    <= yq_next;
        jx_reg    <= jx_next;
        jy_reg    <= jy_next;
    end

    // channel outputs
    assign frame_in.ready      = (state_reg == ST_IDLE);
    assign jitter_out.valid    = out_valid_reg;
    assign jitter_out.jitter_x = jx_reg;
    assign jitter_out.jitter_y = jy_reg;

endmodule
